[rtl/core/lph_pkg.sv]
// Shared types and constants for the linear probe hash table core.
// Depends on nothing; every other file in rtl/core imports it.
package lph_pkg;

  // Key format: ten BCD digits, most significant first
  localparam int KEY_W  = 40;
  localparam int DIGITS = 10;
  // Digit sum bound: DIGITS * 15 fits in eight bits
  localparam int SUM_W  = 8;

  // One memory entry holds the used flag above the key
  localparam int ENTRY_W = KEY_W + 1;

  // Configuration register
  localparam int          TS_W     = 7;
  localparam logic [6:0]  TS_RESET = 7'd64;

  // Result slot index width on the ports
  localparam int OUT_IDX_W = 6;

  // Default table depth
  localparam int SLOTS_DEF = 64;

  // Request codes
  localparam logic [1:0] FUNC_SEARCH = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_FILL,
    ST_WRITE
  } state_t;

endpackage

[rtl/core/linear_probe_hash_table_core.sv]
// Top level of the linear probe hash table core: size register, hash unit, sequencer, memory.
// Depends on lph_pkg, lph_hash, lph_mem and lph_ctrl.
//
// A request (search, insert or delete of a ten-digit BCD key) is taken when start is high
// and busy is low. Its result appears for exactly one cycle with done high; the receiver
// cannot stall it, so capture it on that edge. The hash unit registers the digit sum and
// then runs the eight-step bit-serial remainder. The sequencer then issues reads of the
// slot memory, which has one write port and one registered read port, checks the slots
// in turn, and registers done from the final check. A new request can be taken on the
// edge that ends the done cycle. An insert or delete that changes the table passes
// through a write-back state. An insert that wraps round restarts the scan at slot 0.
// The worst case is an insert that visits every active slot. After reset busy stays
// high while the memory is cleared one slot per cycle. The size register may be
// written at any time cfg_ready is high, but only between requests; values of zero act
// as one slot and values above SLOTS act as SLOTS.
module linear_probe_hash_table_core #(
  parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [lph_pkg::KEY_W-1:0]     phone_digits,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lph_pkg::TS_W-1:0]      cfg_data,
  output logic                          done,
  output logic                          was_present,
  output logic                          changed,
  output logic                          no_slot,
  output logic [lph_pkg::OUT_IDX_W-1:0] slot_index
);
  import lph_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TS_W-1:0]    table_size;
  logic [TS_W-1:0]    size_eff;
  logic               hash_start;
  logic               hash_done;
  logic [IDX_W-1:0]   hash_home;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // Size register takes a write request in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  // Clamp the size to between one slot and the memory depth
  always_comb begin
    if (table_size == '0) begin
      size_eff = TS_W'(1);
    end else if (32'(table_size) > SLOTS) begin
      size_eff = TS_W'(SLOTS);
    end else begin
      size_eff = table_size;
    end
  end

  assign hash_start = start && !busy;

  lph_hash #(
    .SLOTS (SLOTS)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (phone_digits),
    .size  (size_eff),
    .done  (hash_done),
    .home  (hash_home)
  );

  lph_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .phone_digits (phone_digits),
    .size         (size_eff),
    .hash_done    (hash_done),
    .hash_home    (hash_home),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .busy         (busy),
    .done         (done),
    .was_present  (was_present),
    .changed      (changed),
    .no_slot      (no_slot),
    .slot_index   (slot_index)
  );

  // Reads and the write-back of a request never overlap, so no forwarding is needed
  lph_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

[rtl/core/lph_hash.sv]
// Home slot unit: digit sum of the key, then a bit-serial remainder by the table size.
// Depends on lph_pkg.
module lph_hash #(
  parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [lph_pkg::KEY_W-1:0]                  key,
  input  logic [lph_pkg::TS_W-1:0]                   size,
  output logic                                       done,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] home
);
  import lph_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] digit_sum;
  logic [SUM_W-1:0] sum;
  logic [TS_W-1:0]  size_r;
  logic [TS_W-1:0]  rem;
  logic [TS_W:0]    trial;
  logic [TS_W-1:0]  rem_next;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [IDX_W+TS_W-1:0] rem_wide;

  // Add up the key's digits
  always_comb begin
    digit_sum = '0;
    for (int i = 0; i < DIGITS; i++) begin
      digit_sum = digit_sum + SUM_W'(key[4*i +: 4]);
    end
  end

  // One restoring step: bring down the next bit, subtract the size if it fits
  always_comb begin
    trial = {rem, sum[SUM_W-1]};
    if (trial >= {1'b0, size_r}) begin
      trial = trial - {1'b0, size_r};
    end
    rem_next = trial[TS_W-1:0];
  end

  // Hold the dividend and step once per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(SUM_W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum    <= digit_sum;
      size_r <= size;
      rem    <= '0;
    end else if (run) begin
      sum <= {sum[SUM_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  // Remainder is below the size, so it fits the slot index
  assign rem_wide = {{IDX_W{1'b0}}, rem};
  assign home     = rem_wide[IDX_W-1:0];

endmodule

[rtl/core/lph_mem.sv]
// Slot memory: one used flag and one key per slot, one write and one registered read port.
// Depends on lph_pkg.
module lph_mem #(
  parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rd_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output logic [lph_pkg::ENTRY_W-1:0]                rd_data,
  input  logic                                       wr_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  logic [lph_pkg::ENTRY_W-1:0]                wr_data
);
  import lph_pkg::*;

  logic [ENTRY_W-1:0] mem [SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/lph_ctrl.sv]
// Request sequencer: clearing pass, probe scan, wrap-around fill scan and write-back.
// Depends on lph_pkg; drives lph_mem and takes the home slot from lph_hash.
module lph_ctrl #(
  parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  logic [1:0]                                 func,
  input  logic [lph_pkg::KEY_W-1:0]                  phone_digits,
  input  logic [lph_pkg::TS_W-1:0]                   size,
  input  logic                                       hash_done,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] hash_home,
  output logic                                       rd_en,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  logic [lph_pkg::ENTRY_W-1:0]                rd_data,
  output logic                                       wr_en,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  output logic [lph_pkg::ENTRY_W-1:0]                wr_data,
  output logic                                       busy,
  output logic                                       done,
  output logic                                       was_present,
  output logic                                       changed,
  output logic                                       no_slot,
  output logic [lph_pkg::OUT_IDX_W-1:0]              slot_index
);
  import lph_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  state_t state;
  state_t state_next;

  logic [1:0]       func_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] home_r;
  logic [IDX_W-1:0] last_r;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] iss_addr;
  logic             iss_live;
  logic [IDX_W-1:0] chk_addr;
  logic             pend;
  logic [IDX_W-1:0] at_r;
  logic             found_r;

  logic             accept;
  logic             d_used;
  logic             d_hit;
  logic             chk_end;
  logic [IDX_W-1:0] end_addr;
  logic [IDX_W+TS_W-1:0]      last_wide;
  logic [IDX_W+OUT_IDX_W-1:0] at_wide;

  logic             fin;
  logic             fin_found;
  logic             fin_changed;
  logic             fin_noslot;
  logic [IDX_W-1:0] fin_at;

  assign busy   = (state != ST_IDLE);
  assign accept = (state == ST_IDLE) && start;

  // Last active slot, size is never zero here
  assign last_wide = {{IDX_W{1'b0}}, TS_W'(size - TS_W'(1))};

  // Decode the entry returned for the slot under check
  assign d_used   = rd_data[KEY_W];
  assign d_hit    = d_used && (rd_data[KEY_W-1:0] == key_r);
  assign end_addr = (state == ST_FILL) ? IDX_W'(home_r - IDX_W'(1)) : last_r;
  assign chk_end  = (chk_addr == end_addr);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          state_next = (func_r == FUNC_RSVD) ? ST_IDLE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (pend) begin
          if (!d_used) begin
            state_next = (func_r == FUNC_INSERT) ? ST_WRITE : ST_IDLE;
          end else if (d_hit) begin
            state_next = (func_r == FUNC_DELETE) ? ST_WRITE : ST_IDLE;
          end else if (chk_end) begin
            if ((func_r == FUNC_INSERT) && (home_r != '0)) begin
              state_next = ST_FILL;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_FILL: begin
        if (pend) begin
          if (!d_used) begin
            state_next = ST_WRITE;
          end else if (chk_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory accesses and the finishing result
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = iss_addr;
    wr_en       = 1'b0;
    wr_addr     = at_r;
    wr_data     = '0;
    fin         = 1'b0;
    fin_found   = 1'b0;
    fin_changed = 1'b0;
    fin_noslot  = 1'b0;
    fin_at      = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_HASH: begin
        fin = hash_done && (func_r == FUNC_RSVD);
      end
      ST_PROBE: begin
        rd_en = iss_live;
        if (pend) begin
          if (!d_used) begin
            fin = (func_r != FUNC_INSERT);
          end else if (d_hit) begin
            fin       = (func_r != FUNC_DELETE);
            fin_found = 1'b1;
            fin_at    = chk_addr;
          end else if (chk_end) begin
            if (func_r == FUNC_INSERT) begin
              fin        = (home_r == '0);
              fin_noslot = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
        end
      end
      ST_FILL: begin
        rd_en = iss_live;
        if (pend && d_used && chk_end) begin
          fin        = 1'b1;
          fin_noslot = 1'b1;
        end
      end
      ST_WRITE: begin
        wr_en       = 1'b1;
        wr_data     = (func_r == FUNC_INSERT) ? {1'b1, key_r} : '0;
        fin         = 1'b1;
        fin_found   = found_r;
        fin_changed = 1'b1;
        fin_at      = at_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
      iss_live <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      // Drop any read in flight when the scan changes phase
      pend <= (state_next == state) && rd_en;
      if ((state == ST_HASH) && (state_next == ST_PROBE)) begin
        iss_live <= 1'b1;
      end else if ((state == ST_PROBE) && (state_next == ST_FILL)) begin
        iss_live <= 1'b1;
      end else if (rd_en) begin
        iss_live <= (iss_addr != end_addr);
      end
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func;
      key_r   <= phone_digits;
      last_r  <= last_wide[IDX_W-1:0];
      found_r <= 1'b0;
    end
    if ((state == ST_HASH) && hash_done) begin
      home_r   <= hash_home;
      iss_addr <= hash_home;
    end else if ((state == ST_PROBE) && (state_next == ST_FILL)) begin
      iss_addr <= '0;
    end else if (rd_en) begin
      iss_addr <= iss_addr + IDX_W'(1);
    end
    if (rd_en) begin
      chk_addr <= iss_addr;
    end
    // Capture the target slot of a write-back
    if (pend && ((state == ST_PROBE) || (state == ST_FILL)) && (state_next == ST_WRITE)) begin
      at_r    <= chk_addr;
      found_r <= d_hit;
    end
  end

  // Result registers, strobe for one cycle
  assign at_wide = {{OUT_IDX_W{1'b0}}, fin_at};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      was_present <= fin_found;
      changed     <= fin_changed;
      no_slot     <= fin_noslot;
      slot_index  <= at_wide[OUT_IDX_W-1:0];
    end
  end

endmodule
